>>> hdl/sfcca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcca_pkg: shared types and constants for the sensor frame check block
// Transaction payloads, status codes, register indexes, CRC-8 helper and the
// fixed conversion constants.
// ----------------------------------------------------------------------------
package sfcca_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_XFER_FAIL = 2'd1,
    ST_CRC_ERR   = 2'd2
  } status_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_HIGH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HUM_HIGH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HUM_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ENABLES   = 3'd4;

  // Alarm mask bit positions
  localparam int unsigned ALARM_SENSOR    = 0;
  localparam int unsigned ALARM_TEMP_HIGH = 1;
  localparam int unsigned ALARM_TEMP_LOW  = 2;
  localparam int unsigned ALARM_HUM_HIGH  = 3;
  localparam int unsigned ALARM_HUM_LOW   = 4;

  // Enable bit positions
  localparam int unsigned EN_TEMP_HIGH = 0;
  localparam int unsigned EN_TEMP_LOW  = 1;
  localparam int unsigned EN_HUM_HIGH  = 2;
  localparam int unsigned EN_HUM_LOW   = 3;

  // CRC-8 parameters
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion constants
  localparam logic [10:0]        TEMP_SPAN   = 11'd1750;
  localparam logic [9:0]         HUM_SPAN    = 10'd1000;
  localparam logic [16:0]        RAW_FULL    = 17'd65535;
  localparam logic signed [11:0] TEMP_OFFSET = -12'sd450;

  // Queue between classifier and converter
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       transfer_failed;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_check;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
    logic [7:0] hum_check;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic              reading_valid;
    logic signed [11:0] temp_tenths;
    logic [9:0]        hum_tenths;
    logic [4:0]        alarm_mask;
  } out_item_t;

  // Classified frame handed from front to back
  typedef struct packed {
    status_e     status;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
  } frame_t;

  typedef struct packed {
    logic signed [11:0] temp_high;
    logic signed [11:0] temp_low;
    logic [9:0]         hum_high;
    logic [9:0]         hum_low;
    logic [3:0]         enables;
  } cfg_t;

  // Queue handshake seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // One byte of CRC-8, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> hdl/sfcca_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcca_front: frame intake and classification
// Registers the incoming frame with the first CRC byte folded in, finishes
// both CRC checks and pushes a classified frame into the queue.
// ----------------------------------------------------------------------------
module sfcca_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sfcca_pkg::in_item_t    in_data_i,
  input  sfcca_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output sfcca_pkg::frame_t      push_data_o
);

  logic                 f1_valid_q, f1_valid_d;
  sfcca_pkg::in_item_t  f1_item_q;
  logic [7:0]           f1_tcrc_q, f1_hcrc_q;
  logic                 in_accept;
  logic                 temp_ok, hum_ok;

  assign in_stall_o = f1_valid_q && q_status_i.full;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign push_o     = f1_valid_q && !q_status_i.full;

  always_comb begin
    f1_valid_d = f1_valid_q;
    if (in_accept) begin
      f1_valid_d = 1'b1;
    end else if (push_o) begin
      f1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= f1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      f1_item_q <= in_data_i;
      f1_tcrc_q <= sfcca_pkg::crc8_byte(sfcca_pkg::CRC_INIT, in_data_i.temp_msb);
      f1_hcrc_q <= sfcca_pkg::crc8_byte(sfcca_pkg::CRC_INIT, in_data_i.hum_msb);
    end
  end

  // Fold in the low bytes and compare against the received checks
  assign temp_ok = sfcca_pkg::crc8_byte(f1_tcrc_q, f1_item_q.temp_lsb) == f1_item_q.temp_check;
  assign hum_ok  = sfcca_pkg::crc8_byte(f1_hcrc_q, f1_item_q.hum_lsb) == f1_item_q.hum_check;

  always_comb begin
    push_data_o.raw_temp = {f1_item_q.temp_msb, f1_item_q.temp_lsb};
    push_data_o.raw_hum  = {f1_item_q.hum_msb, f1_item_q.hum_lsb};
    if (f1_item_q.transfer_failed) begin
      push_data_o.status = sfcca_pkg::ST_XFER_FAIL;
    end else if (!temp_ok || !hum_ok) begin
      push_data_o.status = sfcca_pkg::ST_CRC_ERR;
    end else begin
      push_data_o.status = sfcca_pkg::ST_OK;
    end
  end

endmodule

>>> hdl/sfcca_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcca_queue: short frame queue
// Decouples the classifier from the converter so each side stalls alone.
// ----------------------------------------------------------------------------
module sfcca_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  sfcca_pkg::frame_t         push_data_i,
  input  logic                      pop_i,
  output sfcca_pkg::frame_t         pop_data_o,
  output sfcca_pkg::queue_status_t  status_o
);

  localparam logic [sfcca_pkg::QPTR_W-1:0] LastPtr =
    sfcca_pkg::QPTR_W'(sfcca_pkg::QUEUE_DEPTH - 1);
  localparam logic [sfcca_pkg::QPTR_W:0] FullCount =
    (sfcca_pkg::QPTR_W + 1)'(sfcca_pkg::QUEUE_DEPTH);

  sfcca_pkg::frame_t                entry_q [sfcca_pkg::QUEUE_DEPTH];
  logic [sfcca_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sfcca_pkg::QPTR_W:0]       count_q, count_d;

  assign status_o.full  = count_q == FullCount;
  assign status_o.empty = count_q == '0;
  assign pop_data_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/sfcca_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcca_back: conversion, stored reading and alarm evaluation
// Scales the raw words in two stages (multiply, then divide by 65535 as a
// shift with one correction), updates the stored reading and drives the
// registered result transaction.
// ----------------------------------------------------------------------------
module sfcca_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfcca_pkg::queue_status_t  q_status_i,
  input  sfcca_pkg::frame_t         pop_data_i,
  output logic                      pop_o,
  input  sfcca_pkg::cfg_t           cfg_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sfcca_pkg::out_item_t      out_data_o
);

  // Product stage
  logic                 p_valid_q;
  sfcca_pkg::status_e   p_status_q;
  logic [26:0]          p_tprod_q;
  logic [25:0]          p_hprod_q;
  logic                 p_ready, p_advance;

  // Converted stage
  logic                 c_valid_q;
  sfcca_pkg::status_e   c_status_q;
  logic signed [11:0]   c_temp_q, c_temp_d;
  logic [9:0]           c_hum_q, c_hum_d;
  logic                 c_ready;

  // Result stage and stored reading
  logic                 out_valid_q;
  sfcca_pkg::out_item_t out_data_q, out_data_d;
  logic                 out_load;
  logic signed [11:0]   st_temp_q, st_temp_d;
  logic [9:0]           st_hum_q, st_hum_d;
  logic                 st_valid;

  // Divide-by-65535 helpers
  logic [10:0]          t_quo, t_div;
  logic [16:0]          t_sum;
  logic [9:0]           h_quo, h_div;
  logic [16:0]          h_sum;

  assign out_load  = c_valid_q && (!out_valid_q || !out_stall_i);
  assign c_ready   = !c_valid_q || out_load;
  assign p_advance = p_valid_q && c_ready;
  assign p_ready   = !p_valid_q || c_ready;
  assign pop_o     = !q_status_i.empty && p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_q <= pop_o;
      end
      if (c_ready) begin
        c_valid_q <= p_advance;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_status_q <= pop_data_i.status;
      p_tprod_q  <= {11'd0, pop_data_i.raw_temp} * {16'd0, sfcca_pkg::TEMP_SPAN};
      p_hprod_q  <= {10'd0, pop_data_i.raw_hum} * {16'd0, sfcca_pkg::HUM_SPAN};
    end
  end

  // floor(p / 65535) = q + ((q + r) >= 65535), with q = p >> 16, r = p mod 2^16
  always_comb begin
    t_quo = p_tprod_q[26:16];
    t_sum = {6'd0, t_quo} + {1'b0, p_tprod_q[15:0]};
    t_div = t_quo + 11'(t_sum >= sfcca_pkg::RAW_FULL);
    h_quo = p_hprod_q[25:16];
    h_sum = {7'd0, h_quo} + {1'b0, p_hprod_q[15:0]};
    h_div = h_quo + 10'(h_sum >= sfcca_pkg::RAW_FULL);
    c_temp_d = $signed({1'b0, t_div}) + sfcca_pkg::TEMP_OFFSET;
    c_hum_d  = (h_div > sfcca_pkg::HUM_SPAN) ? sfcca_pkg::HUM_SPAN : h_div;
  end

  always_ff @(posedge clk_i) begin
    if (p_advance) begin
      c_status_q <= p_status_q;
      c_temp_q   <= c_temp_d;
      c_hum_q    <= c_hum_d;
    end
  end

  // Update the stored reading and evaluate alarms on the updated state
  always_comb begin
    st_temp_d = st_temp_q;
    st_hum_d  = st_hum_q;
    st_valid  = 1'b0;
    if (c_status_q == sfcca_pkg::ST_OK) begin
      st_temp_d = c_temp_q;
      st_hum_d  = c_hum_q;
      st_valid  = 1'b1;
    end
    out_data_d.status        = c_status_q;
    out_data_d.reading_valid = st_valid;
    out_data_d.temp_tenths   = st_temp_d;
    out_data_d.hum_tenths    = st_hum_d;
    out_data_d.alarm_mask    = '0;
    if (!st_valid) begin
      out_data_d.alarm_mask[sfcca_pkg::ALARM_SENSOR] = 1'b1;
    end else begin
      out_data_d.alarm_mask[sfcca_pkg::ALARM_TEMP_HIGH] =
        cfg_i.enables[sfcca_pkg::EN_TEMP_HIGH] &&
        ($signed(st_temp_d) >= $signed(cfg_i.temp_high));
      out_data_d.alarm_mask[sfcca_pkg::ALARM_TEMP_LOW] =
        cfg_i.enables[sfcca_pkg::EN_TEMP_LOW] &&
        ($signed(st_temp_d) <= $signed(cfg_i.temp_low));
      out_data_d.alarm_mask[sfcca_pkg::ALARM_HUM_HIGH] =
        cfg_i.enables[sfcca_pkg::EN_HUM_HIGH] && (st_hum_d >= cfg_i.hum_high);
      out_data_d.alarm_mask[sfcca_pkg::ALARM_HUM_LOW] =
        cfg_i.enables[sfcca_pkg::EN_HUM_LOW] && (st_hum_d <= cfg_i.hum_low);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_temp_q <= '0;
      st_hum_q  <= '0;
    end else if (out_load) begin
      st_temp_q <= st_temp_d;
      st_hum_q  <= st_hum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hdl/sensor_frame_check_convert_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_check_convert_alarm: sensor frame CRC check, scaling, alarms
// Top level: configuration registers, classifier, frame queue, converter.
// ----------------------------------------------------------------------------
// Each accepted transaction is one six-byte sensor frame and yields exactly
// one result transaction. The block takes a new frame every clock cycle
// while in_stall_o is low; a frame's result passes through the intake
// register with the first CRC byte, the queue, the multiply stage, the
// divide stage and the output register. A two-entry queue between
// the classifier and the converter lets the intake keep accepting while the
// output is stalled, until the queue and the intake register fill. Register
// writes take effect at the next edge and must land while no frame is in
// flight. The stored reading resets to zero.
module sensor_frame_check_convert_alarm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sfcca_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sfcca_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [sfcca_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sfcca_pkg::CfgDataW-1:0]      cfg_data_i
);

  sfcca_pkg::cfg_t           cfg_q;
  sfcca_pkg::queue_status_t  q_status;
  sfcca_pkg::frame_t         push_data, pop_data;
  logic                      push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfcca_pkg::CFG_TEMP_HIGH: cfg_q.temp_high <= $signed(cfg_data_i);
        sfcca_pkg::CFG_TEMP_LOW:  cfg_q.temp_low  <= $signed(cfg_data_i);
        sfcca_pkg::CFG_HUM_HIGH:  cfg_q.hum_high  <= cfg_data_i[9:0];
        sfcca_pkg::CFG_HUM_LOW:   cfg_q.hum_low   <= cfg_data_i[9:0];
        sfcca_pkg::CFG_ENABLES:   cfg_q.enables   <= cfg_data_i[3:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  sfcca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sfcca_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  sfcca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // An accepted frame always carries a set valid flag and no sensor fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sfcca_pkg::ST_OK |->
      out_data_o.reading_valid && !out_data_o.alarm_mask[sfcca_pkg::ALARM_SENSOR])
    else $error("accepted frame reported as invalid");

  // An invalid reading reports the sensor fault alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reading_valid |-> out_data_o.alarm_mask == 5'd1)
    else $error("invalid reading with threshold alarms");

  // Intake stalls only when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_status.full && !q_status.empty)
    else $error("intake stalled with room in the queue");

  // Converted humidity never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hum_tenths <= sfcca_pkg::HUM_SPAN)
    else $error("humidity above full scale");

endmodule

>>> dv/sensor_frame_check_convert_alarm_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_check_convert_alarm_test: frame check, scaling and alarm test
// Drives six-byte sensor frames and threshold settings into the block and
// predicts each result: CRC-8 check per word, conversion to tenths, stored
// reading, valid flag and alarm mask. Directed corner frames come first, then
// randomized phases with different idle and stall patterns and limit settings.
// ----------------------------------------------------------------------------
module sensor_frame_check_convert_alarm_test;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerPhase = 90;
  localparam logic [sfcca_pkg::CfgIdxW-1:0] CFG_SPARE = 3'd7;

  // Tracks stored reading and limits; holds the results still to come.
  class reading_tracker;
    logic signed [11:0]   temp_high;
    logic signed [11:0]   temp_low;
    logic [9:0]           hum_high;
    logic [9:0]           hum_low;
    logic [3:0]           enables;
    logic signed [11:0]   stored_temp;
    logic [9:0]           stored_hum;
    logic                 reading_ok;
    sfcca_pkg::out_item_t pending[$];
    int unsigned          frames_noted;
    int unsigned          results_checked;
    int unsigned          mismatches;
    int unsigned          status_count[3];
    logic [4:0]           alarms_seen;

    function new();
      temp_high = '0;
      temp_low = '0;
      hum_high = '0;
      hum_low = '0;
      enables = '0;
      stored_temp = '0;
      stored_hum = '0;
      reading_ok = 1'b1;
      frames_noted = 0;
      results_checked = 0;
      mismatches = 0;
      status_count = '{0, 0, 0};
      alarms_seen = '0;
    endfunction

    // Serial CRC-8 over one two-byte word, MSB first.
    static function logic [7:0] word_crc(logic [7:0] msb, logic [7:0] lsb);
      logic [15:0] w;
      logic [7:0]  c;
      logic        fb;
      w = {msb, lsb};
      c = sfcca_pkg::CRC_INIT;
      for (int i = 15; i >= 0; i--) begin
        fb = c[7] ^ w[i];
        c = {c[6:0], 1'b0} ^ (fb ? sfcca_pkg::CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    function void write_reg(logic [sfcca_pkg::CfgIdxW-1:0] idx,
                            logic [sfcca_pkg::CfgDataW-1:0] value);
      case (idx)
        sfcca_pkg::CFG_TEMP_HIGH: temp_high = value;
        sfcca_pkg::CFG_TEMP_LOW:  temp_low = value;
        sfcca_pkg::CFG_HUM_HIGH:  hum_high = value[9:0];
        sfcca_pkg::CFG_HUM_LOW:   hum_low = value[9:0];
        sfcca_pkg::CFG_ENABLES:   enables = value[3:0];
        default: ;
      endcase
    endfunction

    function void note_frame(sfcca_pkg::in_item_t f);
      sfcca_pkg::out_item_t r;
      int unsigned          raw_t;
      int unsigned          raw_h;
      int unsigned          hum;
      int                   temp;
      logic [4:0]           alarm;
      frames_noted++;
      alarm = '0;
      if (f.transfer_failed) begin
        r.status = sfcca_pkg::ST_XFER_FAIL;
        reading_ok = 1'b0;
      end else if (word_crc(f.temp_msb, f.temp_lsb) != f.temp_check ||
                   word_crc(f.hum_msb, f.hum_lsb) != f.hum_check) begin
        r.status = sfcca_pkg::ST_CRC_ERR;
        reading_ok = 1'b0;
      end else begin
        raw_t = 32'({f.temp_msb, f.temp_lsb});
        raw_h = 32'({f.hum_msb, f.hum_lsb});
        temp = -450 + int'((1750 * raw_t) / 65535);
        hum = (1000 * raw_h) / 65535;
        if (hum > 1000) hum = 1000;
        stored_temp = temp[11:0];
        stored_hum = hum[9:0];
        reading_ok = 1'b1;
        r.status = sfcca_pkg::ST_OK;
      end
      if (!reading_ok) begin
        alarm[sfcca_pkg::ALARM_SENSOR] = 1'b1;
      end else begin
        alarm[sfcca_pkg::ALARM_TEMP_HIGH] =
          enables[sfcca_pkg::EN_TEMP_HIGH] && (stored_temp >= temp_high);
        alarm[sfcca_pkg::ALARM_TEMP_LOW] =
          enables[sfcca_pkg::EN_TEMP_LOW] && (stored_temp <= temp_low);
        alarm[sfcca_pkg::ALARM_HUM_HIGH] =
          enables[sfcca_pkg::EN_HUM_HIGH] && (stored_hum >= hum_high);
        alarm[sfcca_pkg::ALARM_HUM_LOW] =
          enables[sfcca_pkg::EN_HUM_LOW] && (stored_hum <= hum_low);
      end
      r.reading_valid = reading_ok;
      r.temp_tenths = stored_temp;
      r.hum_tenths = stored_hum;
      r.alarm_mask = alarm;
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(sfcca_pkg::out_item_t got);
      sfcca_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", got.status));
        return;
      end
      exp = pending.pop_front();
      results_checked++;
      if (got.status !== exp.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  results_checked, got.status, exp.status));
      if (got.reading_valid !== exp.reading_valid)
        report_mismatch($sformatf("result %0d reading_valid %b, want %b",
                                  results_checked, got.reading_valid, exp.reading_valid));
      if (got.temp_tenths !== exp.temp_tenths)
        report_mismatch($sformatf("result %0d temp_tenths %0d, want %0d",
                                  results_checked, got.temp_tenths, exp.temp_tenths));
      if (got.hum_tenths !== exp.hum_tenths)
        report_mismatch($sformatf("result %0d hum_tenths %0d, want %0d",
                                  results_checked, got.hum_tenths, exp.hum_tenths));
      if (got.alarm_mask !== exp.alarm_mask)
        report_mismatch($sformatf("result %0d alarm_mask %b, want %b",
                                  results_checked, got.alarm_mask, exp.alarm_mask));
      if (exp.status <= sfcca_pkg::ST_CRC_ERR) status_count[exp.status]++;
      alarms_seen |= exp.alarm_mask;
    endtask
  endclass

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  sfcca_pkg::in_item_t            in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sfcca_pkg::out_item_t           out_data;
  logic                           cfg_we = 1'b0;
  logic [sfcca_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [sfcca_pkg::CfgDataW-1:0] cfg_data = '0;

  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    quiet_cycles = 0;
  reading_tracker tracker;

  sensor_frame_check_convert_alarm u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic sfcca_pkg::in_item_t good_frame(logic [15:0] raw_t, logic [15:0] raw_h);
    sfcca_pkg::in_item_t f;
    f.transfer_failed = 1'b0;
    {f.temp_msb, f.temp_lsb} = raw_t;
    {f.hum_msb, f.hum_lsb} = raw_h;
    f.temp_check = reading_tracker::word_crc(raw_t[15:8], raw_t[7:0]);
    f.hum_check = reading_tracker::word_crc(raw_h[15:8], raw_h[7:0]);
    return f;
  endfunction

  function automatic logic [15:0] random_raw();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1: return 16'($urandom_range(15));
      2: return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames; the rest failed transfers and broken checks.
  function automatic sfcca_pkg::in_item_t random_frame();
    sfcca_pkg::in_item_t f;
    int unsigned         pick;
    f = good_frame(random_raw(), random_raw());
    pick = $urandom_range(99);
    if (pick < 8) begin
      f = sfcca_pkg::in_item_t'({1'b1, 48'($urandom) ^ {16'($urandom), 32'h0}});
      if ($urandom_range(1)) f = good_frame(random_raw(), random_raw()) | {1'b1, 48'h0};
    end else if (pick < 22) begin
      case ($urandom_range(2))
        0: f.temp_check ^= 8'($urandom_range(255, 1));
        1: f.hum_check ^= 8'($urandom_range(255, 1));
        default: begin
          f.temp_check ^= 8'($urandom_range(255, 1));
          f.hum_check ^= 8'($urandom_range(255, 1));
        end
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(sfcca_pkg::in_item_t f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (in_stall);
    tracker.note_frame(f);
    @(negedge clk);
  endtask

  // Hold the input until every pending result is back, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [sfcca_pkg::CfgIdxW-1:0] idx,
                           logic [sfcca_pkg::CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic program_limits(logic [sfcca_pkg::CfgDataW-1:0] t_high,
                                logic [sfcca_pkg::CfgDataW-1:0] t_low,
                                logic [sfcca_pkg::CfgDataW-1:0] h_high,
                                logic [sfcca_pkg::CfgDataW-1:0] h_low,
                                logic [sfcca_pkg::CfgDataW-1:0] en);
    write_reg(sfcca_pkg::CFG_TEMP_HIGH, t_high);
    write_reg(sfcca_pkg::CFG_TEMP_LOW, t_low);
    write_reg(sfcca_pkg::CFG_HUM_HIGH, h_high);
    write_reg(sfcca_pkg::CFG_HUM_LOW, h_low);
    write_reg(sfcca_pkg::CFG_ENABLES, en);
    write_reg(CFG_SPARE, 12'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [sfcca_pkg::CfgDataW-1:0] random_temp_limit();
    return 12'(int'($urandom_range(1750)) - 450);
  endfunction

  initial begin
    sfcca_pkg::in_item_t f;
    int unsigned         p;
    int unsigned         k;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full-scale raw values, failures, single and double CRC errors.
    program_limits(12'(-450), 12'(-450), 12'd0, 12'd0, 12'hF);
    send_frame(good_frame(16'h0000, 16'h0000));
    send_frame(good_frame(16'hFFFF, 16'hFFFF));
    f = good_frame(16'h1234, 16'h5678);
    f.transfer_failed = 1'b1;
    send_frame(f);
    f = good_frame(16'hABCD, 16'h1234);
    f.temp_check ^= 8'h01;
    send_frame(f);
    send_frame(good_frame(16'h5555, 16'hAAAA));
    f = good_frame(16'hAAAA, 16'h5555);
    f.hum_check ^= 8'h80;
    send_frame(f);
    f = good_frame(16'hFFFF, 16'h0000);
    f.temp_check = ~f.temp_check;
    f.hum_check = ~f.hum_check;
    f.transfer_failed = 1'b1;
    send_frame(f);
    f.transfer_failed = 1'b0;
    send_frame(f);
    send_frame(good_frame(16'hAAAA, 16'h5555));
    drain();
    // Thresholds sitting exactly on converted values.
    program_limits(12'd425, 12'd425, 12'd500, 12'd500, 12'hF);
    send_frame(good_frame(16'h8000, 16'h8000));
    send_frame(good_frame(16'h7FFF, 16'h7FFF));
    drain();
    program_limits(12'd425, 12'd425, 12'd500, 12'd500, 12'b0101);
    send_frame(good_frame(16'h8000, 16'h8000));
    drain();
    program_limits(12'd0, 12'd0, 12'd0, 12'd0, 12'h0);
    send_frame(good_frame(16'h8000, 16'h0000));
    drain();

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          program_limits(12'(-450), 12'd1300, 12'd0, 12'd1000, 12'hF);
        end
        1: begin
          idle_pct = 47;
          stall_pct = 0;
          program_limits(12'd1300, 12'(-450), 12'd1000, 12'd0, 12'hF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 47;
          program_limits(random_temp_limit(), random_temp_limit(),
                         12'($urandom_range(1000)), 12'($urandom_range(1000)),
                         12'($urandom_range(15)));
        end
        3: begin
          idle_pct = 12;
          stall_pct = 12;
          // Limits beyond the documented range compare as written.
          program_limits(12'h7FF, 12'h800, 12'h3FF, 12'h3FF, 12'($urandom_range(15)));
        end
        default: begin
          idle_pct = 12;
          stall_pct = 12;
          program_limits(random_temp_limit(), random_temp_limit(),
                         12'($urandom_range(1000)), 12'($urandom_range(1000)), 12'hF);
        end
      endcase
      for (k = 0; k < ItemsPerPhase; k++) begin
        if (p == 2 && k == ItemsPerPhase / 2) drain();
        send_frame(random_frame());
      end
      drain();
    end
    stall_pct = 0;

    if (tracker.pending.size() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending.size()));
    $display("Sent %0d frames (directed corners, five randomized phases); %0d results checked",
             tracker.frames_noted, tracker.results_checked);
    $display("Status ok/fail/crc %0d/%0d/%0d, alarm bits exercised %b, mismatches %0d",
             tracker.status_count[sfcca_pkg::ST_OK],
             tracker.status_count[sfcca_pkg::ST_XFER_FAIL],
             tracker.status_count[sfcca_pkg::ST_CRC_ERR], tracker.alarms_seen,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
